// File: hw/rtl/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// bmpd_pkg - shared types and constants for the mono BMP stream decoder
// Result kinds, error codes, the queue command record and header constants.
// ----------------------------------------------------------------------------
package bmpd_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int QUEUE_DEPTH    = 4;

    // header layout (byte positions of the last byte of each field)
    localparam logic [31:0] POS_SIGNATURE = 32'd1;
    localparam logic [31:0] POS_OFFSET    = 32'd13;
    localparam logic [31:0] POS_DIB_SIZE  = 32'd17;
    localparam logic [31:0] POS_WIDTH     = 32'd21;
    localparam logic [31:0] POS_HEIGHT    = 32'd25;
    localparam logic [31:0] POS_PLANES    = 32'd27;
    localparam logic [31:0] POS_DEPTH     = 32'd29;
    localparam logic [31:0] POS_COMPRESS  = 32'd33;
    localparam logic [31:0] POS_HDR_LAST  = 32'd53;
    localparam logic [31:0] HEADER_BYTES  = 32'd54;

    localparam logic [15:0] SIGNATURE_BM  = 16'h4D42;   // "BM" little-endian
    localparam logic [31:0] DIB_SIZE      = 32'd40;

    typedef enum logic [1:0] {
        KIND_SIZE   = 2'd0,
        KIND_PIXELS = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_SIGNATURE  = 4'd1,
        ERR_DIB_SIZE   = 4'd2,
        ERR_PLANES     = 4'd3,
        ERR_COMPRESSED = 4'd4,
        ERR_DEPTH      = 4'd5,
        ERR_SIZE       = 4'd6,
        ERR_OFFSET     = 4'd7,
        ERR_TRUNCATED  = 4'd8
    } err_t;

    // one queued result; fields not used by the kind are zero
    typedef struct packed {
        kind_t       kind;
        err_t        error_code;
        logic [10:0] image_width;
        logic [10:0] image_height;
        logic [9:0]  row_index;
        logic [9:0]  first_column;
        logic [7:0]  data_byte;
        logic [3:0]  pixel_count;
        logic        last_group;
    } cmd_t;

endpackage

// File: hw/rtl/bmpd_front.sv
// ----------------------------------------------------------------------------
// bmpd_front - byte parser
// Tracks file position, assembles header fields, runs the checks and turns
// each pixel byte into a queued group command.
// ----------------------------------------------------------------------------
module bmpd_front
    import bmpd_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] file_byte,
    input  logic       first_of_file,
    input  logic       last_of_file,
    input  logic       q_full,
    output logic       push,
    output cmd_t       push_cmd
);

    localparam int WW            = $clog2(MAX_WIDTH + 1);
    localparam int HW            = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_BYTES_MAX = ((MAX_WIDTH + 31) / 32) * 4;
    localparam int BW            = $clog2(ROW_BYTES_MAX + 1);
    localparam int CW            = BW + 3;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_SKIP   = 5'b00100,
        PH_PIXELS = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    phase_t         phase_reg, phase_next;
    logic [31:0]    pos_reg, pos_next;
    logic [31:0]    field_reg, field_next;
    logic [31:0]    offset_reg, offset_next;
    logic [WW-1:0]  width_reg, width_next;
    logic [HW-1:0]  height_reg, height_next;
    logic           width_ok_reg, width_ok_next;
    logic           height_ok_reg, height_ok_next;
    logic           depth_ok_reg, depth_ok_next;
    logic [HW-1:0]  row_reg, row_next;
    logic [BW-1:0]  col_byte_reg, col_byte_next;

    logic           accept;
    logic [31:0]    pos;
    logic [31:0]    field_old;
    logic [31:0]    field_new;
    logic [BW-1:0]  data_bytes;
    logic [BW-1:0]  row_bytes;
    logic [BW-1:0]  col_byte_inc;
    logic [CW-1:0]  col;
    logic [CW-1:0]  remain;
    logic [HW-1:0]  row_out;
    logic           fin;
    err_t           err;
    logic           emit;
    cmd_t           cmd;

    assign accept     = in_valid && !q_full;
    assign pos        = first_of_file ? 32'd0 : pos_reg;
    assign field_old  = first_of_file ? 32'd0 : field_reg;
    assign field_new  = {file_byte, field_old[31:8]};

    assign data_bytes   = BW'((32'(width_reg) + 32'd7) >> 3);
    assign row_bytes    = BW'(((32'(width_reg) + 32'd31) >> 5) << 2);
    assign col_byte_inc = col_byte_reg + BW'(1);
    assign col          = {col_byte_reg, 3'b000};
    assign remain       = CW'(width_reg) - col;
    assign row_out      = height_reg - HW'(1) - row_reg;
    assign fin          = (row_reg == height_reg - HW'(1)) &&
                          (col_byte_reg == data_bytes - BW'(1));

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        field_next     = field_reg;
        offset_next    = offset_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        width_ok_next  = width_ok_reg;
        height_ok_next = height_ok_reg;
        depth_ok_next  = depth_ok_reg;
        row_next       = row_reg;
        col_byte_next  = col_byte_reg;
        err            = ERR_NONE;
        emit           = 1'b0;
        cmd            = '0;

        if (accept)
        begin
            if (first_of_file)
            begin
                phase_next     = PH_HEADER;
                pos_next       = '0;
                field_next     = '0;
                offset_next    = '0;
                width_next     = '0;
                height_next    = '0;
                width_ok_next  = 1'b0;
                height_ok_next = 1'b0;
                depth_ok_next  = 1'b0;
                row_next       = '0;
                col_byte_next  = '0;
            end

            if (first_of_file || phase_reg == PH_HEADER ||
                phase_reg == PH_SKIP || phase_reg == PH_PIXELS)
            begin
                pos_next = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;

                if (first_of_file || phase_reg == PH_HEADER)
                begin
                    field_next = field_new;
                    unique case (pos)
                        POS_SIGNATURE:
                        begin
                            if (field_new[31:16] != SIGNATURE_BM)
                                err = ERR_SIGNATURE;
                        end
                        POS_OFFSET:
                        begin
                            offset_next = field_new;
                        end
                        POS_DIB_SIZE:
                        begin
                            if (field_new != DIB_SIZE)
                                err = ERR_DIB_SIZE;
                        end
                        POS_WIDTH:
                        begin
                            width_next    = WW'(field_new);
                            width_ok_next = (field_new != 32'd0) &&
                                            (field_new <= 32'(MAX_WIDTH));
                        end
                        POS_HEIGHT:
                        begin
                            height_next    = HW'(field_new);
                            height_ok_next = (field_new != 32'd0) &&
                                             (field_new <= 32'(MAX_HEIGHT));
                        end
                        POS_PLANES:
                        begin
                            if (field_new[31:16] != 16'd1)
                                err = ERR_PLANES;
                        end
                        POS_DEPTH:
                        begin
                            depth_ok_next = (field_new[31:16] == 16'd1);
                        end
                        POS_COMPRESS:
                        begin
                            if (field_new != 32'd0)
                                err = ERR_COMPRESSED;
                        end
                        POS_HDR_LAST:
                        begin
                            if (!depth_ok_reg)
                                err = ERR_DEPTH;
                            else if (!(width_ok_reg && height_ok_reg))
                                err = ERR_SIZE;
                            else if (offset_reg < HEADER_BYTES)
                                err = ERR_OFFSET;
                            else
                            begin
                                emit             = 1'b1;
                                cmd.kind         = KIND_SIZE;
                                cmd.image_width  = 11'(width_reg);
                                cmd.image_height = 11'(height_reg);
                                phase_next       = PH_SKIP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (phase_reg == PH_PIXELS || pos >= offset_reg)
                begin
                    phase_next = PH_PIXELS;
                    if (col_byte_reg < data_bytes)
                    begin
                        emit             = 1'b1;
                        cmd.kind         = KIND_PIXELS;
                        cmd.row_index    = 10'(row_out);
                        cmd.first_column = 10'(col);
                        cmd.data_byte    = file_byte;
                        cmd.pixel_count  = (remain > CW'(8)) ? 4'd8 : 4'(remain);
                        cmd.last_group   = fin;
                        if (fin)
                            phase_next = PH_DONE;
                    end
                    if (col_byte_inc >= row_bytes)
                    begin
                        col_byte_next = '0;
                        row_next      = row_reg + HW'(1);
                    end
                    else
                    begin
                        col_byte_next = col_byte_inc;
                    end
                end

                // truncation only when nothing else went wrong on this beat
                if (err == ERR_NONE && last_of_file && phase_next != PH_DONE)
                    err = ERR_TRUNCATED;

                if (err != ERR_NONE)
                begin
                    emit           = 1'b1;
                    cmd            = '0;
                    cmd.kind       = KIND_ERROR;
                    cmd.error_code = err;
                    phase_next     = PH_DONE;
                end
            end
        end
    end

    assign push     = emit;
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            field_reg     <= '0;
            offset_reg    <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            width_ok_reg  <= 1'b0;
            height_ok_reg <= 1'b0;
            depth_ok_reg  <= 1'b0;
            row_reg       <= '0;
            col_byte_reg  <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            field_reg     <= field_next;
            offset_reg    <= offset_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            width_ok_reg  <= width_ok_next;
            height_ok_reg <= height_ok_next;
            depth_ok_reg  <= depth_ok_next;
            row_reg       <= row_next;
            col_byte_reg  <= col_byte_next;
        end
    end

endmodule

// File: hw/rtl/bmpd_queue.sv
// ----------------------------------------------------------------------------
// bmpd_queue - command queue between parser and output stage
// Small circular buffer; full stalls the parser, empty idles the back end.
// ----------------------------------------------------------------------------
module bmpd_queue
    import bmpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;

    assign full    = (count_reg == NW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + NW'(1);
        else if (pop && !push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/bmpd_back.sv
// ----------------------------------------------------------------------------
// bmpd_back - output stage
// Unpacks pixel bytes (MSB first, inverted, masked) into the output register.
// ----------------------------------------------------------------------------
module bmpd_back
    import bmpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [10:0] image_width,
    output logic [10:0] image_height,
    output logic [9:0]  row_index,
    output logic [9:0]  first_column,
    output logic [7:0]  pixel_bits,
    output logic [3:0]  pixel_count,
    output logic        last_group,
    output logic [3:0]  error_code
);

    logic       valid_reg, valid_next;
    cmd_t       cmd_reg;
    logic [7:0] bits_reg;
    logic [7:0] bits;
    logic       load;

    assign load  = !q_empty && (!valid_reg || !out_stall);
    assign q_pop = load;

    // leftmost pixel is source bit 7; clear bit gives 1
    always_comb
    begin
        for (int i = 0; i < 8; i++)
            bits[i] = (4'(i) < q_cmd.pixel_count) && !q_cmd.data_byte[7 - i];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg  <= q_cmd;
            bits_reg <= bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign out_valid    = valid_reg;
    assign kind         = cmd_reg.kind;
    assign image_width  = cmd_reg.image_width;
    assign image_height = cmd_reg.image_height;
    assign row_index    = cmd_reg.row_index;
    assign first_column = cmd_reg.first_column;
    assign pixel_bits   = bits_reg;
    assign pixel_count  = cmd_reg.pixel_count;
    assign last_group   = cmd_reg.last_group;
    assign error_code   = cmd_reg.error_code;

endmodule

// File: hw/rtl/bmp_mono_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// bmp_mono_stream_decoder_unit - streaming decoder for 1 bpp BMP files
// Parser, command queue and registered output stage.
// ----------------------------------------------------------------------------
// Feed the file one byte per beat, first_of_file on byte 0 and last_of_file on
// the final byte. One byte goes in every unstalled cycle: each byte is a single
// pass through the parser, which updates its counters and field shifter and
// may post one result into a four-deep queue. in_stall rises only when that
// queue is full, which happens only if the output side has been stalled for a
// while; the queue and the output register let the two sides stall on their
// own. A result is on the output at the earliest from the clock edge after the
// one that takes its byte. Results: one size report after byte 53 of a good
// header, then one pixel group per row data byte (padding and trailing bytes
// give nothing), or a single error beat, after which the rest of the file is
// ignored until the next first_of_file. A first_of_file mid-file quietly
// abandons the current one. Widths and heights above MAX_WIDTH / MAX_HEIGHT are
// rejected with the size error; reported width and height are cut to 11 bits.
// ----------------------------------------------------------------------------
module bmp_mono_stream_decoder_unit
    import bmpd_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // byte input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  file_byte,
    input  logic        first_of_file,
    input  logic        last_of_file,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [10:0] image_width,
    output logic [10:0] image_height,
    output logic [9:0]  row_index,
    output logic [9:0]  first_column,
    output logic [7:0]  pixel_bits,
    output logic [3:0]  pixel_count,
    output logic        last_group,
    output logic [3:0]  error_code
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t q_wr_cmd;
    cmd_t q_rd_cmd;

    // stall depends only on queue occupancy, never on in_valid
    assign in_stall = q_full;

    bmpd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .file_byte     (file_byte),
        .first_of_file (first_of_file),
        .last_of_file  (last_of_file),
        .q_full        (q_full),
        .push          (q_push),
        .push_cmd      (q_wr_cmd)
    );

    bmpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_wr_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_rd_cmd),
        .empty    (q_empty)
    );

    bmpd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_cmd        (q_rd_cmd),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .image_width  (image_width),
        .image_height (image_height),
        .row_index    (row_index),
        .first_column (first_column),
        .pixel_bits   (pixel_bits),
        .pixel_count  (pixel_count),
        .last_group   (last_group),
        .error_code   (error_code)
    );

    // a fresh result beat must have come out of the queue
    a_rise_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!q_empty))
        else $error("output beat appeared without a queued command");

    // pixel groups carry 1..8 pixels and no error code
    a_pixel_group: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_PIXELS) |->
            (pixel_count != 4'd0 && pixel_count <= 4'd8 && error_code == ERR_NONE))
        else $error("malformed pixel group");

    // error beats carry a code and nothing else
    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_ERROR) |->
            (error_code != ERR_NONE && pixel_count == 4'd0 &&
             pixel_bits == 8'd0 && image_width == 11'd0))
        else $error("malformed error beat");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for bmp_mono_stream_decoder_unit
// Streams whole BMP files, good and broken, through the byte channel while
// both sides idle and stall at random. A software decoder in the bench
// predicts every result beat, and a checker compares each one field by field.
// ----------------------------------------------------------------------------
module tb
    import bmpd_pkg::*;
();

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [7:0]  file_byte     = 8'h00;
    logic        first_of_file = 1'b0;
    logic        last_of_file  = 1'b0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [1:0]  kind;
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [9:0]  row_index;
    logic [9:0]  first_column;
    logic [7:0]  pixel_bits;
    logic [3:0]  pixel_count;
    logic        last_group;
    logic [3:0]  error_code;

    always #5 clk = ~clk;

    bmp_mono_stream_decoder_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .file_byte     (file_byte),
        .first_of_file (first_of_file),
        .last_of_file  (last_of_file),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .image_width   (image_width),
        .image_height  (image_height),
        .row_index     (row_index),
        .first_column  (first_column),
        .pixel_bits    (pixel_bits),
        .pixel_count   (pixel_count),
        .last_group    (last_group),
        .error_code    (error_code)
    );

    // ------------------------------------------------------------------------
    // Header layout: position of the last byte of each little-endian field
    // ------------------------------------------------------------------------
    localparam logic [31:0] AT_SIGNATURE = 32'd1;
    localparam logic [31:0] AT_OFFSET    = 32'd13;
    localparam logic [31:0] AT_DIB       = 32'd17;
    localparam logic [31:0] AT_WIDTH     = 32'd21;
    localparam logic [31:0] AT_HEIGHT    = 32'd25;
    localparam logic [31:0] AT_PLANES    = 32'd27;
    localparam logic [31:0] AT_DEPTH     = 32'd29;
    localparam logic [31:0] AT_COMPRESS  = 32'd33;
    localparam logic [31:0] AT_HDR_END   = 32'd53;
    localparam logic [31:0] HDR_LEN      = 32'd54;
    localparam logic [31:0] WIDTH_LIMIT  = MAX_WIDTH_DEF;
    localparam logic [31:0] HEIGHT_LIMIT = MAX_HEIGHT_DEF;
    localparam int          GAP_LIMIT    = 600;    // cap on bytes built before pixels

    // fill patterns for pixel data
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZEROS  = 1;
    localparam int FILL_ONES   = 2;

    // ------------------------------------------------------------------------
    // Bench-side decoder state
    // ------------------------------------------------------------------------
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEADER,
        ST_SKIP,
        ST_PIXELS,
        ST_DONE
    } parse_state_t;

    // one result beat, unused fields zero
    typedef struct packed {
        kind_t       kind;
        logic [10:0] image_width;
        logic [10:0] image_height;
        logic [9:0]  row_index;
        logic [9:0]  first_column;
        logic [7:0]  pixel_bits;
        logic [3:0]  pixel_count;
        logic        last_group;
        err_t        error_code;
    } beat_t;

    typedef struct packed {
        logic [15:0] sig;
        logic [31:0] offset;
        logic [31:0] dib;
        logic [31:0] width;
        logic [31:0] height;
        logic [15:0] planes;
        logic [15:0] depth;
        logic [31:0] comp;
    } bmp_header_t;

    parse_state_t pstate;
    logic [31:0]  m_pos;       // bytes taken since first_of_file
    logic [31:0]  m_shift;     // little-endian field assembler
    logic [31:0]  m_offset;
    logic [31:0]  m_width;
    logic [31:0]  m_height;
    logic [31:0]  m_row;       // file row, bottom-up
    logic [31:0]  m_col_byte;  // byte within the padded row
    logic [15:0]  m_depth;

    beat_t        decoded_beats[$];   // beats the decoder owes us, oldest first
    logic [7:0]   file_bytes[$];      // file under construction
    int           fails       = 0;
    int           file_beats  = 0;    // bytes sent as part of a file
    int           fill_mode   = FILL_RANDOM;
    bit           steady      = 1'b0; // no idling on either side while set

    function automatic void clear_file();
        m_pos      = '0;
        m_shift    = '0;
        m_offset   = '0;
        m_width    = '0;
        m_height   = '0;
        m_row      = '0;
        m_col_byte = '0;
        m_depth    = '0;
    endfunction

    // Advance the bench decoder by one accepted byte, queueing any result.
    function automatic void decode_byte(input logic [7:0] b, input logic first,
                                        input logic last);
        beat_t       r;
        err_t        err;
        logic        emit;
        logic        fin;
        logic [31:0] pos;
        logic [31:0] data_bytes;
        logic [31:0] row_bytes;
        logic [31:0] col;
        logic [31:0] cnt;
        logic [31:0] out_row;
        logic [7:0]  bits;
        r    = '0;
        err  = ERR_NONE;
        emit = 1'b0;
        if (first)
        begin
            clear_file();
            pstate = ST_HEADER;
        end
        if (pstate == ST_IDLE || pstate == ST_DONE)
            return;

        pos = m_pos;
        if (m_pos != 32'hFFFF_FFFF)
            m_pos = m_pos + 32'd1;

        if (pstate == ST_HEADER)
        begin
            m_shift = {b, m_shift[31:8]};
            case (pos)
                AT_SIGNATURE: if (m_shift[31:16] != SIGNATURE_BM) err = ERR_SIGNATURE;
                AT_OFFSET:    m_offset = m_shift;
                AT_DIB:       if (m_shift != DIB_SIZE) err = ERR_DIB_SIZE;
                AT_WIDTH:     m_width = m_shift;
                AT_HEIGHT:    m_height = m_shift;
                AT_PLANES:    if (m_shift[31:16] != 16'd1) err = ERR_PLANES;
                AT_DEPTH:     m_depth = m_shift[31:16];
                AT_COMPRESS:  if (m_shift != 32'd0) err = ERR_COMPRESSED;
                AT_HDR_END:
                begin
                    // depth, then size, then offset
                    if (m_depth != 16'd1)
                        err = ERR_DEPTH;
                    else if (m_width == 0 || m_width > WIDTH_LIMIT ||
                             m_height == 0 || m_height > HEIGHT_LIMIT)
                        err = ERR_SIZE;
                    else if (m_offset < HDR_LEN)
                        err = ERR_OFFSET;
                    else
                    begin
                        r.kind         = KIND_SIZE;
                        r.image_width  = m_width[10:0];
                        r.image_height = m_height[10:0];
                        emit           = 1'b1;
                        pstate         = ST_SKIP;
                    end
                end
                default: ;
            endcase
        end
        else
        begin
            if (pstate == ST_SKIP && pos >= m_offset)
                pstate = ST_PIXELS;
            if (pstate == ST_PIXELS)
            begin
                data_bytes = (m_width + 32'd7) >> 3;
                row_bytes  = ((m_width + 32'd31) >> 5) << 2;
                if (m_col_byte < data_bytes)
                begin
                    col = m_col_byte << 3;
                    cnt = m_width - col;
                    if (cnt > 32'd8)
                        cnt = 32'd8;
                    // MSB first; a clear source bit is a set pixel
                    bits = '0;
                    for (int i = 0; i < cnt; i++)
                        bits[i] = ~b[7 - i];
                    fin = (m_row == m_height - 32'd1) &&
                          (m_col_byte == data_bytes - 32'd1);
                    out_row        = m_height - 32'd1 - m_row;
                    r.kind         = KIND_PIXELS;
                    r.row_index    = out_row[9:0];
                    r.first_column = col[9:0];
                    r.pixel_bits   = bits;
                    r.pixel_count  = cnt[3:0];
                    r.last_group   = fin;
                    emit           = 1'b1;
                    if (fin)
                        pstate = ST_DONE;
                end
                m_col_byte = m_col_byte + 32'd1;
                if (m_col_byte >= row_bytes)
                begin
                    m_col_byte = '0;
                    m_row      = m_row + 32'd1;
                end
            end
        end

        // a short file overrides any size report or group due on this byte
        if (err == ERR_NONE && last && pstate != ST_DONE)
            err = ERR_TRUNCATED;
        if (err != ERR_NONE)
        begin
            r            = '0;
            r.kind       = KIND_ERROR;
            r.error_code = err;
            emit         = 1'b1;
            pstate       = ST_DONE;
        end
        if (emit)
            decoded_beats.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // File construction
    // ------------------------------------------------------------------------
    function automatic bmp_header_t good_header(input int w, input int h, input int off);
        bmp_header_t hd;
        hd.sig    = SIGNATURE_BM;
        hd.offset = off;
        hd.dib    = DIB_SIZE;
        hd.width  = w;
        hd.height = h;
        hd.planes = 16'd1;
        hd.depth  = 16'd1;
        hd.comp   = 32'd0;
        return hd;
    endfunction

    function automatic void push_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic logic [7:0] pixel_byte();
        if (fill_mode == FILL_ZEROS)
            return 8'h00;
        if (fill_mode == FILL_ONES)
            return 8'hFF;
        return $urandom;
    endfunction

    // Header, filler up to the pixel offset, padded rows when the size is
    // usable, then trailing junk.
    function automatic void build_file(input bmp_header_t hd, input int trailing);
        int row_bytes;
        file_bytes.delete();
        push_le(hd.sig, 2);
        push_le($urandom, 4);          // file size, not checked
        push_le($urandom, 4);          // reserved
        push_le(hd.offset, 4);
        push_le(hd.dib, 4);
        push_le(hd.width, 4);
        push_le(hd.height, 4);
        push_le(hd.planes, 2);
        push_le(hd.depth, 2);
        push_le(hd.comp, 4);
        repeat (20) push_le($urandom, 1);
        while (file_bytes.size() < hd.offset && file_bytes.size() < GAP_LIMIT)
            push_le($urandom, 1);
        if (hd.width != 0 && hd.width <= WIDTH_LIMIT &&
            hd.height != 0 && hd.height <= HEIGHT_LIMIT)
        begin
            row_bytes = ((hd.width + 31) >> 5) << 2;
            for (int r = 0; r < hd.height; r++)
                for (int c = 0; c < row_bytes; c++)
                    file_bytes.push_back(pixel_byte());
        end
        repeat (trailing) push_le($urandom, 1);
    endfunction

    // ------------------------------------------------------------------------
    // Byte channel driver
    // ------------------------------------------------------------------------
    // Entered just after a falling edge. Leaves valid high on exit so that
    // back-to-back beats never lower and raise it in the same time step.
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        while (!steady && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        file_byte     <= b;
        first_of_file <= first;
        last_of_file  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(b, first, last);
        @(negedge clk);
    endtask

    // Send the first n bytes of file_bytes; last_at < 0 means no last flag.
    task automatic send_file(input int n, input int last_at);
        for (int i = 0; i < n; i++)
        begin
            send_byte(file_bytes[i], i == 0, i == last_at);
            file_beats++;
        end
    endtask

    task automatic send_image(input int w, input int h, input int off, input int trailing);
        build_file(good_header(w, h, off), trailing);
        send_file(file_bytes.size(), file_bytes.size() - 1);
    endtask

    // Stops once the file has ended for the decoder; later bytes are ignored.
    task automatic send_header_case(input bmp_header_t hd);
        build_file(hd, 2);
        for (int i = 0; i < file_bytes.size(); i++)
        begin
            send_byte(file_bytes[i], i == 0, i == file_bytes.size() - 1);
            file_beats++;
            if (pstate == ST_DONE)
                break;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall, checker
    // ------------------------------------------------------------------------
    always @(negedge clk)
        out_stall <= steady ? 1'b0 : ($urandom_range(99) < 19);

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        beat_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (decoded_beats.size() == 0)
            begin
                $error("result beat with nothing outstanding: kind %0d", kind);
                fails++;
            end
            else
            begin
                want = decoded_beats.pop_front();
                check_field("kind",         want.kind,         kind);
                check_field("image_width",  want.image_width,  image_width);
                check_field("image_height", want.image_height, image_height);
                check_field("row_index",    want.row_index,    row_index);
                check_field("first_column", want.first_column, first_column);
                check_field("pixel_bits",   want.pixel_bits,   pixel_bits);
                check_field("pixel_count",  want.pixel_count,  pixel_count);
                check_field("last_group",   want.last_group,   last_group);
                check_field("error_code",   want.error_code,   error_code);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Bytes before any first_of_file must be dropped, last flag or not.
    task automatic test_idle_noise();
        send_byte(8'h42, 1'b0, 1'b0);
        send_byte(8'h4D, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0);
    endtask

    // Well-formed images: narrow, byte-aligned, padded rows, a gap before
    // the pixels, trailing junk, the widest image and a tall narrow one.
    task automatic test_good_images();
        send_image(1, 1, 54, 0);
        fill_mode = FILL_ZEROS;
        send_image(8, 2, 54, 0);
        fill_mode = FILL_ONES;
        send_image(9, 1, 56, 2);
        fill_mode = FILL_RANDOM;
        send_image(33, 2, 54, 1);
        send_image(32, 3, 60, 0);
        send_image(64, 1, 54, 3);
        send_image(WIDTH_LIMIT, 1, 54, 0);
        send_image(1, 8, 54, 0);
    endtask

    // One bad header field at a time, plus the precedence at the end of the
    // DIB header (depth over size over offset).
    task automatic test_header_errors();
        bmp_header_t hd;
        hd = good_header(8, 2, 54); hd.sig    = 16'h4D43;       send_header_case(hd);
        hd = good_header(8, 2, 54); hd.sig    = 16'h4E42;       send_header_case(hd);
        hd = good_header(8, 2, 54); hd.dib    = 32'd12;         send_header_case(hd);
        hd = good_header(8, 2, 54); hd.planes = 16'd0;          send_header_case(hd);
        hd = good_header(8, 2, 54); hd.planes = 16'd2;          send_header_case(hd);
        hd = good_header(8, 2, 54); hd.comp   = 32'd1;          send_header_case(hd);
        hd = good_header(8, 2, 54); hd.comp   = 32'h8000_0000;  send_header_case(hd);
        hd = good_header(8, 2, 54); hd.depth  = 16'd8;          send_header_case(hd);
        hd = good_header(0, 2, 10); hd.depth  = 16'd0;          send_header_case(hd);
        hd = good_header(0, 2, 54);                             send_header_case(hd);
        hd = good_header(WIDTH_LIMIT + 1, 2, 54);               send_header_case(hd);
        hd = good_header(8, 2, 54); hd.width  = 32'hFFFF_FFFF;  send_header_case(hd);
        hd = good_header(8, 0, 54);                             send_header_case(hd);
        hd = good_header(8, HEIGHT_LIMIT + 1, 54);              send_header_case(hd);
        hd = good_header(8, -4, 54);                            send_header_case(hd);
        hd = good_header(8, 2, 53);                             send_header_case(hd);
        hd = good_header(8, 2, 0);                              send_header_case(hd);
        hd = good_header(0, 2, 10);                             send_header_case(hd);
    endtask

    // last_of_file before the image is complete, at each stage of the file.
    task automatic test_truncation();
        bmp_header_t hd;
        build_file(good_header(8, 2, 54), 0);
        send_file(1, 0);                      // one-byte file
        send_file(2, 1);                      // ends on a good signature
        send_file(11, 10);                    // ends inside the header
        send_file(54, 53);                    // ends where the size report is due
        send_file(56, 55);                    // ends on a padding byte
        build_file(good_header(16, 2, 62), 0);
        send_file(58, 57);                    // ends in the gap before the pixels
        send_file(64, 63);                    // ends mid-row
        hd = good_header(8, 2, 54);
        hd.sig = 16'h0000;
        build_file(hd, 0);
        send_file(2, 1);                      // the signature error wins
    endtask

    // first_of_file mid-file drops the old file without a word.
    task automatic test_restart();
        build_file(good_header(24, 3, 54), 0);
        send_file(30, -1);
        send_image(24, 3, 54, 0);
        send_file(60, -1);
        send_image(12, 2, 58, 1);
        // trailing bytes after completion, one with last set
        send_byte(8'hAA, 1'b0, 1'b1);
        send_byte(8'h55, 1'b0, 1'b0);
    endtask

    // Long run with neither side idling at all.
    task automatic test_steady_stream();
        steady = 1'b1;
        repeat (3)
            send_image($urandom_range(1, 48), $urandom_range(1, 4), 54, $urandom_range(0, 2));
        steady = 1'b0;
    endtask

    // Mostly well-formed files with random content; the rest corrupt,
    // truncated, abandoned or stray bytes.
    task automatic random_file();
        bmp_header_t hd;
        int          w;
        int          h;
        int          n;
        int          sel;
        int          cut;
        w   = ($urandom_range(9) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 40);
        h   = $urandom_range(1, 5);
        hd  = good_header(w, h, 54 + (($urandom_range(3) == 0) ? $urandom_range(1, 12) : 0));
        sel = $urandom_range(99);
        if (sel < 70)
        begin
            build_file(hd, $urandom_range(0, 3));
            send_file(file_bytes.size(), file_bytes.size() - 1);
        end
        else if (sel < 80)
        begin
            case ($urandom_range(7))
                0: hd.sig    = $urandom;
                1: hd.dib    = $urandom_range(0, 200);
                2: hd.planes = $urandom;
                3: hd.comp   = $urandom_range(1, 6);
                4: hd.depth  = $urandom_range(0, 32);
                5: hd.width  = $urandom_range(1) ? $urandom : 32'd0;
                6: hd.height = $urandom_range(1) ? $urandom : -h;
                default: hd.offset = $urandom_range(0, 53);
            endcase
            send_header_case(hd);
        end
        else if (sel < 88)
        begin
            build_file(hd, 1);
            n   = file_bytes.size();
            cut = $urandom_range(0, n - 1);
            send_file(cut + 1, cut);
        end
        else if (sel < 94)
        begin
            build_file(hd, 0);
            send_file($urandom_range(1, file_bytes.size() - 1), -1);
        end
        else
        begin
            // stray bytes: ignored after an end, carried on after an abandon
            repeat ($urandom_range(1, 6))
                send_byte($urandom, 1'b0, $urandom_range(1));
        end
    endtask

    task automatic test_random_files();
        int goal;
        goal = file_beats + 200;
        while (file_beats < goal)
            random_file();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        pstate = ST_IDLE;
        clear_file();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_noise();
        test_good_images();
        test_header_errors();
        test_truncation();
        test_restart();
        test_steady_stream();
        test_random_files();

        in_valid <= 1'b0;
        while (decoded_beats.size() != 0)
            @(posedge clk);
        // catch any beat the block should not have produced
        repeat (40) @(posedge clk);
        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hang guard: far beyond the slowest legal run.
    initial
    begin
        #(5_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
